### hw/rtl/dnsd_pkg.sv
// ----------------------------------------------------------------------------
// dnsd_pkg
// shared constants, codes and types of the dns name decompressor
// ----------------------------------------------------------------------------
`default_nettype none

package dnsd_pkg;

    // message store
    localparam int MSG_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MSG_BYTES);

    // pointer space of a 14-bit compression pointer
    localparam int PTR_SPACE = 'h4000;
    localparam int PTR_W     = $clog2(PTR_SPACE);
    localparam int POS_W     = PTR_W + 1;

    // hop limit
    localparam int MAX_HOPS  = 64;
    localparam int HOP_W     = $clog2(MAX_HOPS + 2);

    // field widths
    localparam int IN_ADDR_W = 12;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 3;
    localparam int CONS_W    = 9;
    localparam int NAME_W    = 8;
    localparam int LEN_W     = 6;

    localparam logic [POS_W-1:0]  STORE_END = POS_W'(MSG_BYTES);
    localparam logic [HOP_W-1:0]  HOP_LIMIT = HOP_W'(MAX_HOPS);
    localparam logic [BYTE_W-1:0] TAG_MASK  = 8'hc0;
    localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3f;
    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2e;
    localparam logic [NAME_W:0]   NAME_MAX  = 9'd255;
    localparam logic [CNT_W-1:0]  WORD_FULL = 3'd4;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_DECODE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_TAG  = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_HOPS     = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef struct packed {
        logic                 valid;
        t_func                func;
        logic [IN_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]    data;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  cnt;
        logic              last;
        t_status           status;
        logic [CONS_W-1:0] consumed;
    } t_emit;

endpackage

`default_nettype wire

### hw/rtl/dns_name_decompressor_core.sv
// ----------------------------------------------------------------------------
// dns_name_decompressor_core
// dns name expansion with compression pointers over a loaded message store
// ----------------------------------------------------------------------------
// steps: a store write is taken only while idle; a decode passes S_LEN and S_HEAD per length
//   byte, also S_PTR per pointer, S_CHAR per label character, S_DOT per dot, then S_FIN and the output reg
// throughput: one byte of the store read port per cycle bounds the walk, and output back-pressure
//   can stall it; 4 characters go out per transaction, the last one of a name carries up to 4
// reset: clears the walker and output valid; store contents stay undefined
//   until written, with no clearing pass
`default_nettype none

module dns_name_decompressor_core
    import dnsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // addr[11:0], data[19:12], zero pad
    input  wire logic        i_s_axis_tuser,  // func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,  // name_bytes[31:0], byte_count[34:32],
                                              // status[37:35], consumed_len[46:38], pad
    output logic             o_m_axis_tlast
);

    t_req        req;
    t_emit       emit;
    logic        emit_ready;

    logic        r_m_valid;
    logic [47:0] r_m_data;
    logic        r_m_last;

    assign req.valid = i_s_axis_tvalid;
    assign req.func  = t_func'(i_s_axis_tuser);
    assign req.addr  = i_s_axis_tdata[IN_ADDR_W-1:0];
    assign req.data  = i_s_axis_tdata[IN_ADDR_W+BYTE_W-1:IN_ADDR_W];

    dnsd_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_req_ready  (o_s_axis_tready),
        .o_emit       (emit),
        .i_emit_ready (emit_ready)
    );

    // output register
    assign emit_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit_ready) begin
            r_m_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid && emit_ready) begin
            r_m_data <= {1'b0, emit.consumed, emit.status, emit.cnt, emit.word};
            r_m_last <= emit.last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

### hw/rtl/dnsd_walker.sv
// ----------------------------------------------------------------------------
// dnsd_walker
// message store and label walker: loads bytes, expands names into words
// ----------------------------------------------------------------------------
`default_nettype none

module dnsd_walker
    import dnsd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_req  i_req,
    output logic       o_req_ready,
    output t_emit      o_emit,
    input  wire logic  i_emit_ready
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LEN  = 7'b0000010,
        S_HEAD = 7'b0000100,
        S_PTR  = 7'b0001000,
        S_CHAR = 7'b0010000,
        S_DOT  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [NAME_W-1:0]   r_n, n_n;
    logic [HOP_W-1:0]    r_hops, n_hops;
    logic [CONS_W-1:0]   r_cons, n_cons;
    logic                r_jumped, n_jumped;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LEN_W-1:0]    r_left, n_left;
    logic [LEN_W-1:0]    r_low6, n_low6;
    t_status             r_status, n_status;

    logic [BYTE_W-1:0]   r_mem [MSG_BYTES];
    logic [BYTE_W-1:0]   r_rd_data;

    logic                mem_we;
    logic                mem_re;
    logic [POS_W-1:0]    wr_pos;
    logic [POS_W-1:0]    rd_pos;

    logic [POS_W-1:0]    pos_next;
    logic [POS_W-1:0]    pos_len;
    logic [NAME_W:0]     n_plus;
    logic [POS_W-1:0]    target;
    logic [HOP_W-1:0]    hops_inc;
    logic [BYTE_W-1:0]   app_char;
    logic [WORD_W-1:0]   app_word;
    logic [CNT_W-1:0]    app_cnt;
    logic                app_ok;

    // store access
    assign o_req_ready = (r_state == S_IDLE);
    assign wr_pos      = POS_W'(i_req.addr);
    assign mem_we      = i_req.valid && o_req_ready && (i_req.func == FUNC_WRITE)
                         && (wr_pos < STORE_END);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_pos[ADDR_W-1:0]] <= i_req.data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_pos[ADDR_W-1:0]];
        end
    end

    // label arithmetic
    assign pos_next = r_pos + POS_W'(1);
    assign pos_len  = r_pos + POS_W'(r_rd_data[LEN_W-1:0]);
    assign n_plus   = {1'b0, r_n} + (NAME_W+1)'(r_rd_data[LEN_W-1:0]) + (NAME_W+1)'(1);
    assign target   = POS_W'({r_low6, r_rd_data});
    assign hops_inc = r_hops + HOP_W'(1);

    // character packing
    assign app_char = (r_state == S_DOT) ? DOT_CHAR : r_rd_data;
    assign app_ok   = (r_cnt != WORD_FULL) || i_emit_ready;

    always_comb begin
        if (r_cnt == WORD_FULL) begin
            app_word = WORD_W'(app_char);
            app_cnt  = CNT_W'(1);
        end else begin
            app_word = r_word | (WORD_W'(app_char) << {r_cnt[1:0], 3'b000});
            app_cnt  = r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_n      = r_n;
        n_hops   = r_hops;
        n_cons   = r_cons;
        n_jumped = r_jumped;
        n_word   = r_word;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_low6   = r_low6;
        n_status = r_status;
        mem_re   = 1'b0;
        rd_pos   = r_pos;
        o_emit   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && (i_req.func == FUNC_DECODE)) begin
                    n_pos    = POS_W'(i_req.addr);
                    n_n      = '0;
                    n_hops   = '0;
                    n_cons   = '0;
                    n_jumped = 1'b0;
                    n_word   = '0;
                    n_cnt    = '0;
                    n_status = ST_OK;
                    n_state  = S_LEN;
                end
            end
            S_LEN: begin
                if (r_pos >= STORE_END) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_rd_data == '0) begin
                    if (!r_jumped) begin
                        n_cons = r_cons + CONS_W'(1);
                    end
                    n_state = S_FIN;
                end else if ((r_rd_data & TAG_MASK) == TAG_MASK) begin
                    if (pos_next >= STORE_END) begin
                        n_status = ST_RANGE;
                        n_state  = S_FIN;
                    end else begin
                        mem_re = 1'b1;
                        rd_pos = pos_next;
                        n_low6 = r_rd_data[LEN_W-1:0];
                        if (!r_jumped) begin
                            n_cons   = r_cons + CONS_W'(2);
                            n_jumped = 1'b1;
                        end
                        n_state = S_PTR;
                    end
                end else if ((r_rd_data & TAG_MASK) != '0) begin
                    n_status = ST_BAD_TAG;
                    n_state  = S_FIN;
                end else if (n_plus > NAME_MAX) begin
                    n_status = ST_TOO_LONG;
                    n_state  = S_FIN;
                end else if (pos_len >= STORE_END) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    mem_re = 1'b1;
                    rd_pos = pos_next;
                    n_pos  = pos_next;
                    n_left = r_rd_data[LEN_W-1:0];
                    n_n    = n_plus[NAME_W-1:0];
                    if (!r_jumped) begin
                        n_cons = r_cons + CONS_W'(r_rd_data[LEN_W-1:0]) + CONS_W'(1);
                    end
                    n_state = S_CHAR;
                end
            end
            S_PTR: begin
                if (hops_inc > HOP_LIMIT) begin
                    n_status = ST_HOPS;
                    n_state  = S_FIN;
                end else if (target >= STORE_END) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    n_hops  = hops_inc;
                    n_pos   = target;
                    n_state = S_LEN;
                end
            end
            S_CHAR: begin
                if (app_ok) begin
                    if (r_cnt == WORD_FULL) begin
                        o_emit.valid = 1'b1;
                        o_emit.word  = r_word;
                        o_emit.cnt   = WORD_FULL;
                    end
                    n_word = app_word;
                    n_cnt  = app_cnt;
                    n_pos  = pos_next;
                    n_left = r_left - LEN_W'(1);
                    if (r_left != LEN_W'(1)) begin
                        mem_re = 1'b1;
                        rd_pos = pos_next;
                    end else begin
                        n_state = S_DOT;
                    end
                end
            end
            S_DOT: begin
                if (app_ok) begin
                    if (r_cnt == WORD_FULL) begin
                        o_emit.valid = 1'b1;
                        o_emit.word  = r_word;
                        o_emit.cnt   = WORD_FULL;
                    end
                    n_word  = app_word;
                    n_cnt   = app_cnt;
                    n_state = S_LEN;
                end
            end
            S_FIN: begin
                o_emit.valid    = 1'b1;
                o_emit.word     = r_word;
                o_emit.cnt      = r_cnt;
                o_emit.last     = 1'b1;
                o_emit.status   = r_status;
                o_emit.consumed = (r_status == ST_OK) ? r_cons : '0;
                if (i_emit_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_left   <= '0;
            r_hops   <= '0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_hops   <= n_hops;
            r_n      <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cons   <= n_cons;
        r_jumped <= n_jumped;
        r_word   <= n_word;
        r_low6   <= n_low6;
        r_status <= n_status;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= WORD_FULL)
        else $error("word fill count out of range");

    a_char_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAR) |-> (r_left != '0))
        else $error("label copy with no characters left");

    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && !o_emit.last) |-> (o_emit.cnt == WORD_FULL))
        else $error("partial word flushed before end of name");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !mem_we)
        else $error("store written during a decode");

    a_hop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hops <= HOP_LIMIT)
        else $error("hop count beyond limit");

endmodule

`default_nettype wire
